// ===== hw/rtl/conv3_pkg.sv =====
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants of the 3x3 convolution block
// Payload structs of both channels, register indexes and output constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package conv3_pkg;

  typedef struct packed {
    logic [14:0] pixel_value;
    logic        drain;
  } pix_in_t;

  typedef struct packed {
    logic [14:0] filtered_value;
    logic        end_of_frame;
  } pix_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 54;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV12  = 3'd4;

  localparam int BLEND_TARGET = 32000;
  localparam int CLAMP_HIGH   = 31999;
  localparam int BIAS_FULL    = 256;

endpackage

// ===== hw/rtl/conv3x3_edge_extend_bias_clamp.sv =====
// One item at a time: an item with a result passes the line update, the nine-tap MAC
// loop, two divide steps, the blend multiply, the add and clamp and the output state; one
// without returns to idle after the line update, and a drain during the frame stays idle.
// The result waits in an output register while the next item is taken.
// Reset (rst_ni low, async): positions and window clear, registers take their
// reset values; the line RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// conv3x3_edge_extend_bias_clamp: 3x3 convolution with edge extend and blend
// Two line buffers in one RAM word per column, a 3x3 window, a shared MAC,
// optional reciprocal divide by 12, bias blend toward 32000 and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_edge_extend_bias_clamp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  conv3_pkg::pix_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output conv3_pkg::pix_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int PB    = PIXEL_BITS;
  localparam int ADR_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int ACC_W = PB + 10;
  localparam int DN    = ACC_W - 3;
  localparam longint unsigned RECIP3 = ((64'd1 << (DN + 2)) + 64'd2) / 64'd3;
  localparam int RC_W  = DN + 1;
  localparam int DP_W  = DN + RC_W;
  localparam int BL_W  = ACC_W + 10;
  localparam int T_W   = ACC_W + 11;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_DIV2 = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  // configuration
  logic [53:0]  kern_q;
  logic [WD_W-1:0] fw_q;
  logic [HT_W-1:0] fh_q;
  logic [8:0]   bias_q;
  logic         div12_q;

  // positions
  logic [ADR_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [ADR_W-1:0] out_col_q, out_col_d;
  logic [HT_W-1:0]  out_row_q, out_row_d;

  logic [PB-1:0] win_q [9];
  logic [PB-1:0] win_d [9];
  logic [PB-1:0] px_q;
  logic [PB-1:0] op_q [9];
  logic [PB-1:0] op_d [9];
  logic          eof_q, eof_d;
  logic [3:0]    k_q;

  logic signed [ACC_W-1:0] acc_q;
  logic [DP_W-1:0]         dprod_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] sd_q;
  logic signed [BL_W-1:0]  bl_q;
  logic [14:0]             res_q;

  logic                    out_valid_q;
  conv3_pkg::pix_out_t     out_data_q;

  // RAM: high half is the older row, low half the newer row
  logic [2*PB-1:0] rdata;
  logic [PB-1:0]   top, mid;
  logic            ram_we;

  logic in_xfer;
  logic flushing;
  logic emit;
  logic up, dn, lf, rt;
  logic [PB-1:0] colL [3];
  logic [PB-1:0] colC [3];
  logic [PB-1:0] colR [3];
  logic [PB-1:0] newc [3];
  logic [ADR_W:0] in_col_inc;
  logic [ADR_W:0] out_col_inc;
  logic           last_col_in, last_col_out, eof_now;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign flushing   = {{(32-ROW_W){1'b0}}, in_row_q} >= {{(32-HT_W){1'b0}}, fh_q};
  assign ram_we     = (state_q == ST_UPD);

  conv3_ram #(
    .WIDTH(2 * PB),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i ({mid, px_q}),
    .re_i    (in_xfer),
    .raddr_i (in_col_q),
    .rdata_o (rdata)
  );

  assign top = rdata[2*PB-1:PB];
  assign mid = rdata[PB-1:0];

  // window update and edge-extended tap selection
  always_comb begin
    newc[0] = top;
    newc[1] = mid;
    newc[2] = px_q;
    emit = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
      win_d[r*3+2] = newc[r];
      colL[r] = win_q[r*3+1];
      colC[r] = win_q[r*3+2];
      // on the first column the result belongs to the previous row's last pixel
      colR[r] = (in_col_q == '0) ? win_q[r*3] : newc[r];
    end
    up = (out_row_q != '0);
    dn = ({1'b0, out_row_q} + (HT_W+1)'(1)) < {1'b0, fh_q};
    lf = (out_col_q != '0);
    rt = ((ADR_W+1)'(out_col_q) + (ADR_W+1)'(1)) < (ADR_W+1)'(fw_q);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        logic rok, cok;
        logic [PB-1:0] v;
        rok = (r == 0) ? up : ((r == 2) ? dn : 1'b1);
        cok = (c == 0) ? lf : ((c == 2) ? rt : 1'b1);
        v = (c == 0) ? colL[r] : ((c == 1) ? colC[r] : colR[r]);
        op_d[r*3+c] = (rok && cok) ? v : colC[1];
      end
    end
  end

  // position bookkeeping
  always_comb begin
    in_col_inc   = (ADR_W+1)'(in_col_q) + (ADR_W+1)'(1);
    out_col_inc  = (ADR_W+1)'(out_col_q) + (ADR_W+1)'(1);
    last_col_in  = in_col_inc >= (ADR_W+1)'(fw_q);
    last_col_out = out_col_inc >= (ADR_W+1)'(fw_q);
    eof_now      = last_col_out &&
                   (({1'b0, out_row_q} + (HT_W+1)'(1)) == {1'b0, fh_q});
    in_col_d  = last_col_in ? '0 : in_col_inc[ADR_W-1:0];
    in_row_d  = last_col_in ? in_row_q + ROW_W'(1) : in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    eof_d     = 1'b0;
    if (emit) begin
      eof_d     = eof_now;
      out_col_d = last_col_out ? '0 : out_col_inc[ADR_W-1:0];
      out_row_d = last_col_out ? out_row_q + HT_W'(1) : out_row_q;
      if (eof_now) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && !(in_data_i.drain && !flushing)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD:  state_d = emit ? ST_MAC : ST_IDLE;
      ST_MAC:  state_d = (k_q == 4'd8) ? ST_DIV1 : ST_MAC;
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // arithmetic
  logic signed [5:0]       coef;
  logic signed [PB+6:0]    mprod;
  logic [ACC_W-1:0]        abs_acc;
  logic [DN-1:0]           quo;
  logic signed [T_W-1:0]   tsum;
  logic signed [T_W-1:0]   tdiv;
  logic [14:0]             clamped;

  always_comb begin
    coef    = $signed(kern_q[6*k_q +: 6]);
    mprod   = coef * $signed({1'b0, op_q[k_q]});
    abs_acc = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    quo     = DN'(dprod_q >> (DN + 2));
    tsum    = T_W'(bl_q) + T_W'(signed'({1'b0, bias_q}) * conv3_pkg::BLEND_TARGET);
    // divide by 256 truncating toward zero
    tdiv    = tsum[T_W-1] ? ((tsum + T_W'(255)) >>> 8) : (tsum >>> 8);
    if (tdiv[T_W-1]) begin
      clamped = '0;
    end else if (tdiv > T_W'(conv3_pkg::CLAMP_HIGH)) begin
      clamped = 15'(conv3_pkg::CLAMP_HIGH);
    end else begin
      clamped = tdiv[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kern_q      <= '0;
      fw_q        <= WD_W'(320);
      fh_q        <= HT_W'(240);
      bias_q      <= '0;
      div12_q     <= 1'b0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          conv3_pkg::CFG_KERNEL: kern_q <= cfg_wdata_i[53:0];
          conv3_pkg::CFG_WIDTH: begin
            if (cfg_wdata_i[10:0] == '0) begin
              fw_q <= WD_W'(1);
            end else if (32'(cfg_wdata_i[10:0]) > MAX_WIDTH) begin
              fw_q <= WD_W'(MAX_WIDTH);
            end else begin
              fw_q <= WD_W'(cfg_wdata_i[10:0]);
            end
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          conv3_pkg::CFG_HEIGHT: begin
            if (cfg_wdata_i[10:0] == '0) begin
              fh_q <= HT_W'(1);
            end else if (32'(cfg_wdata_i[10:0]) > MAX_HEIGHT) begin
              fh_q <= HT_W'(MAX_HEIGHT);
            end else begin
              fh_q <= HT_W'(cfg_wdata_i[10:0]);
            end
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          conv3_pkg::CFG_BIAS: begin
            bias_q <= (cfg_wdata_i[8:0] > 9'(conv3_pkg::BIAS_FULL)) ?
                      9'(conv3_pkg::BIAS_FULL) : cfg_wdata_i[8:0];
          end
          conv3_pkg::CFG_DIV12: div12_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (state_q == ST_UPD) begin
        for (int i = 0; i < 9; i++) begin
          win_q[i] <= win_d[i];
        end
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        k_q       <= '0;
      end
      if (state_q == ST_MAC) begin
        k_q <= k_q + 4'd1;
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= flushing ? '0 : PB'(in_data_i.pixel_value);
    end
    case (state_q)
      ST_UPD: begin
        for (int i = 0; i < 9; i++) begin
          op_q[i] <= op_d[i];
        end
        eof_q <= eof_d;
        acc_q <= '0;
      end
      ST_MAC:  acc_q <= acc_q + ACC_W'(mprod);
      ST_DIV1: begin
        // |sum| / 12 = (|sum| >> 2) / 3 via reciprocal
        dprod_q <= DP_W'(abs_acc[ACC_W-1:2]) * DP_W'(RC_W'(RECIP3));
        neg_q   <= acc_q[ACC_W-1];
      end
      ST_DIV2: begin
        if (div12_q) begin
          sd_q <= neg_q ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));
        end else begin
          sd_q <= acc_q;
        end
      end
      ST_MUL:  bl_q <= BL_W'(sd_q * $signed(10'(conv3_pkg::BIAS_FULL) - {1'b0, bias_q}));
      ST_ADD:  res_q <= clamped;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_data_q.filtered_value <= res_q;
          out_data_q.end_of_frame   <= eof_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/conv3_ram.sv =====
// ----------------------------------------------------------------------------
// conv3_ram: generic single-write, single-read RAM
// One write port, one read port with read enable, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/conv3_checker.sv =====
// ----------------------------------------------------------------------------
// conv3_checker: port-level assertions for the 3x3 convolution block
// Watches the channel ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input conv3_pkg::pix_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input conv3_pkg::pix_out_t out_data_o
);

  // a result waiting for its transfer stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed before its transfer");

  // clamp range
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.filtered_value <= 15'd31999)
    else $error("result above clamp limit");

  // a pixel transfer always occupies the line update cycle
  a_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.drain |=> !in_ready_o)
    else $error("input ready during line update");

  // a new result can only follow a pixel or drain transfer, never rise out of idle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o, 1))
    else $error("result appeared while idle");

endmodule

bind conv3x3_edge_extend_bias_clamp conv3_checker u_conv3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
